[design/hmbs_pkg.sv]
// ---------------------------------------------------------------------------
// hmbs_pkg
// Shared widths, codes and constants for the wrapped 3x3 height smoother.
// ---------------------------------------------------------------------------
package hmbs_pkg;

  localparam int H_W    = 16;  // q8.8 height
  localparam int IDX_W  = 6;   // column / row index of a word
  localparam int SIZE_W = 7;   // size registers and wrapped neighbor indices
  localparam int SUM_W  = 20;  // exact nine-term sum, q12.8
  localparam int MAG_W  = 19;  // magnitude of the sum

  // floor(n / 9) == (n * DIV9_MUL) >> DIV9_SHIFT for n < 2**21
  localparam int               DIV9_SHIFT = 21;
  localparam int               DIV9_MUL_W = 18;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 18'd233017;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_LAST  = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

[design/hmbs_if.sv]
// ---------------------------------------------------------------------------
// hmbs_if
// Valid/ready channels for request words and result words.
// ---------------------------------------------------------------------------
interface hmbs_in_if import hmbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [IDX_W-1:0]        col_index;
  logic [IDX_W-1:0]        row_index;
  logic signed [H_W-1:0]   height_in;

  modport source (output valid, action, col_index, row_index, height_in, input ready);
  modport sink   (input valid, action, col_index, row_index, height_in, output ready);
endinterface

interface hmbs_out_if import hmbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [H_W-1:0]   smoothed_height;
  logic                    index_error;

  modport source (output valid, smoothed_height, index_error, input ready);
  modport sink   (input valid, smoothed_height, index_error, output ready);
endinterface

[design/hmbs_store.sv]
// ---------------------------------------------------------------------------
// hmbs_store
// Single-port height memory with a registered read port.
// ---------------------------------------------------------------------------
module hmbs_store import hmbs_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [AW-1:0]     addr,
  input  logic [H_W-1:0]    wr_data,
  output logic [H_W-1:0]    rd_data
);

  logic [H_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end else if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

[design/hmbs_div9.sv]
// ---------------------------------------------------------------------------
// hmbs_div9
// Signed divide by nine, truncating toward zero, by reciprocal multiply.
// ---------------------------------------------------------------------------
module hmbs_div9 import hmbs_pkg::*; (
  input  logic                    clk,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum,
  output logic signed [H_W-1:0]   quot
);

  logic [SUM_W-1:0]            abs_w;
  logic [MAG_W-1:0]            mag_w;
  logic [MAG_W+DIV9_MUL_W-1:0] prod_w;
  logic [H_W-1:0]              qmag_r;
  logic                        neg_r;

  assign abs_w  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign mag_w  = abs_w[MAG_W-1:0];
  assign prod_w = (MAG_W+DIV9_MUL_W)'(mag_w) * (MAG_W+DIV9_MUL_W)'(DIV9_MUL);

  always_ff @(posedge clk) begin
    if (start) begin
      qmag_r <= prod_w[DIV9_SHIFT+H_W-1:DIV9_SHIFT];
      neg_r  <= sum[SUM_W-1];
    end
  end

  assign quot = neg_r ? H_W'(-qmag_r) : qmag_r;

endmodule

[design/heightmap_box_smooth_wrap_unit.sv]
// ---------------------------------------------------------------------------
// heightmap_box_smooth_wrap_unit
// Height map store with a wrapped 3x3 box-mean read.
// ---------------------------------------------------------------------------
// A write word produces no result; an out-of-range write is dropped. A
// read word inside the configured size holds off the next word: nine
// neighbor reads through the single store port in S_FETCH, S_LAST for the
// last read data, S_DIV for the divide by nine and S_DONE to load the
// result register. An out-of-range read goes to S_DONE and returns zero
// with index_error set. The result register lets the next word enter
// while a result waits. Size registers are taken as 1 when zero and as the
// maximum when too large; the store needs no clearing after reset.
module heightmap_box_smooth_wrap_unit import hmbs_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  hmbs_in_if.sink           in_word,
  hmbs_out_if.source        out_word,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CLIM  = (MAX_COLS > 127) ? 127 : MAX_COLS;
  localparam int RLIM  = (MAX_ROWS > 127) ? 127 : MAX_ROWS;

  state_t                  state_r, state_nxt;
  logic [SIZE_W-1:0]       cols_r, rows_r;
  logic [SIZE_W-1:0]       ncols_w, nrows_w;
  logic [SIZE_W-1:0]       col_w, row_w;
  logic                    inside_w, accept_w;
  logic [SIZE_W-1:0]       cm_r, cc_r, cp_r, rm_r, rc_r, rp_r;
  logic [1:0]              ci_r, ri_r;
  logic [SIZE_W-1:0]       sel_c_w, sel_r_w;
  logic                    pend_r, err_r;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_addr;
  logic [H_W-1:0]          rd_data;
  logic signed [H_W-1:0]   quot_w;
  logic                    out_valid_r, out_err_r;
  logic signed [H_W-1:0]   out_h_r;

  function automatic logic [AW-1:0] lin_addr(logic [SIZE_W-1:0] c, logic [SIZE_W-1:0] r);
    logic [31:0] a;
    a = 32'(c) * 32'(MAX_ROWS) + 32'(r);
    return a[AW-1:0];
  endfunction

  // effective sizes
  assign ncols_w = (cols_r == '0) ? SIZE_W'(1) :
                   (cols_r > SIZE_W'(CLIM)) ? SIZE_W'(CLIM) : cols_r;
  assign nrows_w = (rows_r == '0) ? SIZE_W'(1) :
                   (rows_r > SIZE_W'(RLIM)) ? SIZE_W'(RLIM) : rows_r;

  assign col_w    = {1'b0, in_word.col_index};
  assign row_w    = {1'b0, in_word.row_index};
  assign inside_w = (col_w < ncols_w) && (row_w < nrows_w);

  assign in_word.ready = (state_r == S_IDLE);
  assign accept_w      = in_word.valid && in_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= SIZE_RESET;
      rows_r <= SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_COLS) begin
        cols_r <= cfg_wdata;
      end else begin
        rows_r <= cfg_wdata;
      end
    end
  end

  // neighbor selection
  always_comb begin
    case (ci_r)
      2'd0:    sel_c_w = cm_r;
      2'd1:    sel_c_w = cc_r;
      default: sel_c_w = cp_r;
    endcase
    case (ri_r)
      2'd0:    sel_r_w = rm_r;
      2'd1:    sel_r_w = rc_r;
      default: sel_r_w = rp_r;
    endcase
  end

  assign mem_we   = accept_w && (in_word.action == ACT_WRITE) && inside_w;
  assign mem_re   = (state_r == S_FETCH);
  assign mem_addr = (state_r == S_IDLE) ? lin_addr(col_w, row_w) : lin_addr(sel_c_w, sel_r_w);

  hmbs_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .rd_en   (mem_re),
    .addr    (mem_addr),
    .wr_data (in_word.height_in),
    .rd_data (rd_data)
  );

  hmbs_div9 u_div9 (
    .clk   (clk),
    .start (state_r == S_DIV),
    .sum   (sum_r),
    .quot  (quot_w)
  );

  assign sum_nxt = sum_r + {{(SUM_W-H_W){rd_data[H_W-1]}}, rd_data};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept_w && (in_word.action == ACT_READ)) begin
          state_nxt = inside_w ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: begin
        if (ci_r == 2'd2 && ri_r == 2'd2) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST:  state_nxt = S_DIV;
      S_DIV:   state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_word.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ci_r        <= '0;
      ri_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= mem_re;
      if (state_r == S_FETCH) begin
        if (ri_r == 2'd2) begin
          ri_r <= '0;
          ci_r <= (ci_r == 2'd2) ? 2'd0 : ci_r + 2'd1;
        end else begin
          ri_r <= ri_r + 2'd1;
        end
      end
      if (state_r == S_DONE && (!out_valid_r || out_word.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept_w) begin
      cc_r  <= col_w;
      rc_r  <= row_w;
      cm_r  <= (col_w == '0) ? ncols_w - SIZE_W'(1) : col_w - SIZE_W'(1);
      cp_r  <= (col_w + SIZE_W'(1) == ncols_w) ? '0 : col_w + SIZE_W'(1);
      rm_r  <= (row_w == '0) ? nrows_w - SIZE_W'(1) : row_w - SIZE_W'(1);
      rp_r  <= (row_w + SIZE_W'(1) == nrows_w) ? '0 : row_w + SIZE_W'(1);
      err_r <= !inside_w;
      sum_r <= '0;
    end else if (pend_r) begin
      sum_r <= sum_nxt;
    end
    if (state_r == S_DONE && (!out_valid_r || out_word.ready)) begin
      out_err_r <= err_r;
      out_h_r   <= err_r ? '0 : quot_w;
    end
  end

  assign out_word.valid           = out_valid_r;
  assign out_word.smoothed_height = out_h_r;
  assign out_word.index_error     = out_err_r;

  // store is written only between reads
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE))
    else $error("store write during a read sequence");

  // last neighbor data is in flight when the sum closes
  a_last_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAST) |-> pend_r)
    else $error("sum closed without last store data");

  // an index error always carries a zero height
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_h_r == '0))
    else $error("index error with nonzero height");

endmodule
